// File: design/dip_pkg.sv
// shared types and constants for the decimal integer parser
// no dependencies; imported by dip_step and decimal_int_parser_core
`default_nettype none

package dip_pkg;

	// parse phase codes
	localparam logic [1:0] PH_START  = 2'd0;
	localparam logic [1:0] PH_SPACE  = 2'd1;
	localparam logic [1:0] PH_DIGITS = 2'd2;
	localparam logic [1:0] PH_DONE   = 2'd3;

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;

	localparam int          CONS_W   = 12;
	localparam logic [16:0] CONS_MAX = 17'd4095;

	typedef struct packed {
		logic [1:0]  phase;
		logic        negative;
		logic [31:0] magnitude;
		logic        failed;
	} parse_state_t;

	typedef struct packed {
		logic               ok;
		logic signed [31:0] value;
		logic [CONS_W-1:0]  consumed;
	} parse_result_t;

endpackage

`default_nettype wire

// File: design/decimal_int_parser_core.sv
// top level of the streaming decimal integer parser
// depends on dip_pkg and dip_step
`default_nettype none

// decimal_int_parser_core
// parses a signed 32-bit decimal integer from a character stream
// input channel s_*: one character per transfer, s_tlast on the final character
// of a string. accepted characters are: optional '-' or '+', whitespace only
// after a sign, then digits; parsing stops at the first non-digit and the rest
// of the string is ignored
// output channel m_*: exactly one transfer per string, made after its last
// character. m_tuser is ok; on error value and consumed are zero
// path: a character sits in the input register after its transfer; when it
// advances, the parse state and the result register update, and m_tvalid
// comes from the result register; a string end may wait in the input register
// throughput: one character per cycle unless a string end waits; the loops
// close through the parse state: shift-add by ten with range compare, and count
// stall: when m_tready is low the result register holds; characters that do
// not end a string keep flowing, a string end waits for the result register
// reset: arst_n clears the parse state, the count and both valid flags

module decimal_int_parser_core #(
	parameter int MAX_CHARS = 4095
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] character
	input  logic        s_tlast,   // last_char
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [31:0] value, [43:32] consumed, [47:44] zero
	output logic        m_tuser    // ok
);
	import dip_pkg::*;

	localparam int POS_W = $clog2(MAX_CHARS + 1);

	// input register
	logic       valid_s1;
	logic [7:0] chr_s1;
	logic       last_s1;

	// parse state
	parse_state_t     st_q;
	logic [POS_W-1:0] pos_q;

	// result register
	logic          res_valid_q;
	parse_result_t res_q;

	parse_state_t     st_nxt;
	logic [POS_W-1:0] pos_nxt;
	parse_result_t    res_nxt;

	logic out_free;
	logic adv_s1;

	// a string end needs the result register, other characters always advance
	assign out_free = !res_valid_q || m_tready;
	assign adv_s1   = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			chr_s1  <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	dip_step #(
		.MAX_CHARS (MAX_CHARS),
		.POS_W     (POS_W)
	) u_step (
		.st      (st_q),
		.pos     (pos_q),
		.chr     (chr_s1),
		.nxt     (st_nxt),
		.nxt_pos (pos_nxt),
		.res     (res_nxt)
	);

	// parse state updates once per character, cleared after a string end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= '0;
			pos_q <= '0;
		end else if (adv_s1) begin
			if (last_s1) begin
				st_q  <= '0;
				pos_q <= '0;
			end else begin
				st_q  <= st_nxt;
				pos_q <= pos_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (m_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			res_q <= res_nxt;
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tuser  = res_q.ok;
	assign m_tdata  = {4'b0, res_q.consumed, res_q.value};

	// a string end that leaves the input register always produces a result
	assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_s1 |=> m_tvalid)
		else $error("string end did not produce a result");

	// parse state is back at the start after a string end
	assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_s1 |=> (st_q == '0) && (pos_q == '0))
		else $error("parse state not cleared after string end");

	// an error result carries zero payload
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> (m_tdata == '0))
		else $error("error result with nonzero payload");

	// an ok result has consumed at least one character
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata[43:32] != '0))
		else $error("ok result with zero consumed count");

endmodule

`default_nettype wire

// File: design/dip_step.sv
// per-character next-state logic: sign, whitespace, digit accumulate with range check
// depends on dip_pkg
`default_nettype none

module dip_step #(
	parameter int MAX_CHARS = 4095,
	parameter int POS_W     = 12
) (
	input  dip_pkg::parse_state_t  st,
	input  logic [POS_W-1:0]       pos,
	input  logic [7:0]             chr,
	output dip_pkg::parse_state_t  nxt,
	output logic [POS_W-1:0]       nxt_pos,
	output dip_pkg::parse_result_t res
);
	import dip_pkg::*;

	logic        digit_hit;
	logic        ws_hit;
	logic        take;
	logic        cnt;
	logic [35:0] acc;
	logic [35:0] limit;
	logic [16:0] pos_ext;

	assign digit_hit = (chr >= CH_ZERO) && (chr <= CH_NINE);
	assign ws_hit = (chr == CH_SP) || (chr == CH_TAB) || (chr == CH_LF) ||
		(chr == CH_VT) || (chr == CH_FF) || (chr == CH_CR);

	// magnitude * 10 + digit as shift-add
	assign acc = ({4'b0, st.magnitude} << 3) + ({4'b0, st.magnitude} << 1) +
		{32'b0, chr[3:0]};
	assign limit = st.negative ? 36'h0_8000_0000 : 36'h0_7FFF_FFFF;

	always_comb begin
		nxt  = st;
		take = 1'b0;
		cnt  = 1'b0;
		if (!st.failed) begin
			unique case (st.phase)
				PH_START: begin
					priority if (chr == CH_MINUS) begin
						nxt.negative = 1'b1;
						nxt.phase    = PH_SPACE;
						cnt          = 1'b1;
					end else if (chr == CH_PLUS) begin
						nxt.phase = PH_SPACE;
						cnt       = 1'b1;
					end else if (digit_hit) begin
						nxt.phase = PH_DIGITS;
						take      = 1'b1;
					end else begin
						nxt.failed = 1'b1;
					end
				end
				PH_SPACE: begin
					priority if (ws_hit) begin
						cnt = 1'b1;
					end else if (digit_hit) begin
						nxt.phase = PH_DIGITS;
						take      = 1'b1;
					end else begin
						nxt.failed = 1'b1;
					end
				end
				PH_DIGITS: begin
					if (digit_hit) begin
						take = 1'b1;
					end else begin
						nxt.phase = PH_DONE;
					end
				end
				PH_DONE: begin
				end
				default: begin
				end
			endcase
		end
		if (take) begin
			if (acc > limit) begin
				nxt.failed = 1'b1;
			end else begin
				nxt.magnitude = acc[31:0];
				cnt           = 1'b1;
			end
		end
	end

	// saturating character count
	always_comb begin
		nxt_pos = pos;
		if (cnt && (pos < POS_W'(MAX_CHARS))) begin
			nxt_pos = pos + POS_W'(1);
		end
	end

	assign pos_ext = 17'(nxt_pos);

	always_comb begin
		res.ok = !nxt.failed && ((nxt.phase == PH_DIGITS) || (nxt.phase == PH_DONE));
		if (res.ok) begin
			res.value    = nxt.negative ? -$signed(nxt.magnitude) : $signed(nxt.magnitude);
			res.consumed = (pos_ext > CONS_MAX) ? CONS_MAX[CONS_W-1:0]
				: pos_ext[CONS_W-1:0];
		end else begin
			res.value    = '0;
			res.consumed = '0;
		end
	end

endmodule

`default_nettype wire
